// File: sv/ssa_pkg.sv
package ssa_pkg;

    // Width of one Q7.8 score code
    localparam int SCORE_W = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SORT_INIT,
        ST_SORT_HEAD,
        ST_SORT_SCAN,
        ST_SORT_SWAP_PICK,
        ST_SORT_SWAP_FIRST,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } ssa_state_t;

endpackage

// File: sv/ssa_ram.sv
module ssa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/ssa_div.sv
module ssa_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/selection_sort_with_average_core.sv
// Collects a set of unsigned Q7.8 scores, one per input request, and after the request marked
// final_score sorts the stored set ascending by selection sort and emits one result per stored
// score, each carrying the truncated mean of the set, the overflow flag and end_of_run on the
// last one. Scores arriving when MAX_SCORES are already stored (a final one included) are
// dropped and set overflowed for that set. Loading accepts one score per cycle while in_ready
// is high. After the final request the block holds in_ready low while it works: a restoring
// divider first computes the mean, then the sort, which reads the single-read-port score
// memory at most once per cycle through one shared compare, makes one pass for each
// first = 0 .. n - 2, and emission then hands out the sorted scores as the sink takes them.
// in_ready returns the cycle after the result carrying end_of_run is taken, with count, total
// and overflow cleared for the next set.
module selection_sort_with_average_core #(
    parameter int MAX_SCORES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ssa_pkg::SCORE_W-1:0] score,
    input  logic                       final_score,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ssa_pkg::SCORE_W-1:0] sorted_score,
    output logic [ssa_pkg::SCORE_W-1:0] mean_score,
    output logic                       overflowed,
    output logic                       end_of_run
);

    localparam int SW      = ssa_pkg::SCORE_W;
    localparam int ADDR_W  = $clog2(MAX_SCORES);
    localparam int CNT_W   = $clog2(MAX_SCORES + 1);
    localparam int TOTAL_W = SW + CNT_W;
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SCORES);

    ssa_pkg::ssa_state_t state_reg, state_next;

    // Control state, cleared by reset
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               dropped_reg, dropped_next;

    // Sort and emission working registers
    logic [SW-1:0]      mean_reg, mean_next;
    logic [ADDR_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]  pick_reg, pick_next;
    logic [SW-1:0]      least_reg, least_next;
    logic [SW-1:0]      first_val_reg, first_val_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [SW-1:0]      sorted_score_reg, sorted_score_next;
    logic               end_of_run_reg, end_of_run_next;

    // Memory and divider hookup
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [SW-1:0]      wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [SW-1:0]      rd_data;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_quotient;

    ssa_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SCORES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssa_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        total_next        = total_reg;
        dropped_next      = dropped_reg;
        mean_next         = mean_reg;
        first_next        = first_reg;
        scan_next         = scan_reg;
        cmp_idx_next      = cmp_idx_reg;
        pick_next         = pick_reg;
        least_next        = least_reg;
        first_val_next    = first_val_reg;
        k_next            = k_reg;
        sorted_score_next = sorted_score_reg;
        end_of_run_next   = end_of_run_reg;
        wr_en             = 1'b0;
        wr_addr           = first_reg;
        wr_data           = first_val_reg;
        rd_addr           = k_reg;
        div_start         = 1'b0;

        unique case (state_reg)
            ssa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Store while there is room, otherwise drop and flag
                    if (count_reg < MAX_COUNT)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[ADDR_W-1:0];
                        wr_data    = score;
                        count_next = count_reg + 1'b1;
                        total_next = total_reg + TOTAL_W'(score);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (final_score)
                    begin
                        state_next = ssa_pkg::ST_DIV_START;
                    end
                end
            end

            ssa_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ssa_pkg::ST_DIV_WAIT;
            end

            ssa_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    // Mean never exceeds the largest code, so the low bits hold it
                    mean_next  = div_quotient[SW-1:0];
                    first_next = '0;
                    k_next     = '0;
                    if (count_reg > CNT_W'(1))
                    begin
                        state_next = ssa_pkg::ST_SORT_INIT;
                    end
                    else
                    begin
                        state_next = ssa_pkg::ST_EMIT_READ;
                    end
                end
            end

            ssa_pkg::ST_SORT_INIT:
            begin
                rd_addr    = first_reg;
                scan_next  = CNT_W'(first_reg) + CNT_W'(1);
                state_next = ssa_pkg::ST_SORT_HEAD;
            end

            ssa_pkg::ST_SORT_HEAD:
            begin
                // Head of the pass seeds the running minimum; issue the first scan read
                least_next     = rd_data;
                first_val_next = rd_data;
                pick_next      = first_reg;
                rd_addr        = scan_reg[ADDR_W-1:0];
                cmp_idx_next   = scan_reg[ADDR_W-1:0];
                scan_next      = scan_reg + 1'b1;
                state_next     = ssa_pkg::ST_SORT_SCAN;
            end

            ssa_pkg::ST_SORT_SCAN:
            begin
                // Strict compare keeps the first minimum found
                if (rd_data < least_reg)
                begin
                    least_next = rd_data;
                    pick_next  = cmp_idx_reg;
                end
                if (scan_reg < count_reg)
                begin
                    rd_addr      = scan_reg[ADDR_W-1:0];
                    cmp_idx_next = scan_reg[ADDR_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = ssa_pkg::ST_SORT_SWAP_PICK;
                end
            end

            ssa_pkg::ST_SORT_SWAP_PICK:
            begin
                wr_en      = 1'b1;
                wr_addr    = pick_reg;
                wr_data    = first_val_reg;
                state_next = ssa_pkg::ST_SORT_SWAP_FIRST;
            end

            ssa_pkg::ST_SORT_SWAP_FIRST:
            begin
                // Written second so that a pick equal to first keeps the minimum
                wr_en      = 1'b1;
                wr_addr    = first_reg;
                wr_data    = least_reg;
                first_next = first_reg + 1'b1;
                if ((CNT_W'(first_reg) + CNT_W'(2)) < count_reg)
                begin
                    state_next = ssa_pkg::ST_SORT_INIT;
                end
                else
                begin
                    state_next = ssa_pkg::ST_EMIT_READ;
                end
            end

            ssa_pkg::ST_EMIT_READ:
            begin
                rd_addr    = k_reg;
                state_next = ssa_pkg::ST_EMIT_LOAD;
            end

            ssa_pkg::ST_EMIT_LOAD:
            begin
                sorted_score_next = rd_data;
                end_of_run_next   = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
                state_next        = ssa_pkg::ST_EMIT_WAIT;
            end

            ssa_pkg::ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    if (end_of_run_reg)
                    begin
                        // Drop the set and reopen the input
                        count_next   = '0;
                        total_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ssa_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // Advance and prefetch the next sorted entry
                        k_next     = k_reg + 1'b1;
                        rd_addr    = k_reg + 1'b1;
                        state_next = ssa_pkg::ST_EMIT_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ssa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ssa_pkg::ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg         <= mean_next;
        first_reg        <= first_next;
        scan_reg         <= scan_next;
        cmp_idx_reg      <= cmp_idx_next;
        pick_reg         <= pick_next;
        least_reg        <= least_next;
        first_val_reg    <= first_val_next;
        k_reg            <= k_next;
        sorted_score_reg <= sorted_score_next;
        end_of_run_reg   <= end_of_run_next;
    end

    assign in_ready     = (state_reg == ssa_pkg::ST_IDLE);
    assign out_valid    = (state_reg == ssa_pkg::ST_EMIT_WAIT);
    assign sorted_score = sorted_score_reg;
    assign mean_score   = mean_reg;
    assign overflowed   = dropped_reg;
    assign end_of_run   = end_of_run_reg;

endmodule

// File: sv/ssa_checker.sv
module ssa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ssa_pkg::SCORE_W-1:0] sorted_score,
    input logic [ssa_pkg::SCORE_W-1:0] mean_score,
    input logic                        overflowed,
    input logic                        end_of_run
);

    logic                        in_run_reg;
    logic [ssa_pkg::SCORE_W-1:0] prev_score_reg;
    logic [ssa_pkg::SCORE_W-1:0] prev_mean_reg;
    logic                        prev_over_reg;

    // Track the last result taken within the current set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            in_run_reg <= !end_of_run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            prev_score_reg <= sorted_score;
            prev_mean_reg  <= mean_score;
            prev_over_reg  <= overflowed;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while a result is pending");

    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_run_reg) |-> (sorted_score >= prev_score_reg))
        else $error("results not in ascending order");

    a_set_constant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_run_reg) |->
            ((mean_score == prev_mean_reg) && (overflowed == prev_over_reg)))
        else $error("mean or overflow changed within a set");

    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_run) |=> in_ready)
        else $error("input not reopened after end of set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sorted_score)
            && $stable(end_of_run)))
        else $error("stalled result changed");

endmodule

bind selection_sort_with_average_core ssa_checker u_ssa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_score (sorted_score),
    .mean_score   (mean_score),
    .overflowed   (overflowed),
    .end_of_run   (end_of_run)
);

// File: tb/score_sort_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the score sorter, predicts the sorted results from
// the accepted requests, and compares every emitted result in order.
module score_sort_checker #(
    parameter int MAX_SCORES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [ssa_pkg::SCORE_W-1:0] score,
    input  logic                        final_score,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [ssa_pkg::SCORE_W-1:0] sorted_score,
    input  logic [ssa_pkg::SCORE_W-1:0] mean_score,
    input  logic                        overflowed,
    input  logic                        end_of_run,
    output int                          fail_count,
    output int                          results_due
);

    typedef logic [ssa_pkg::SCORE_W-1:0] code_t;

    typedef struct packed {
        code_t sorted;
        code_t mean;
        logic  ovf;
        logic  eor;
    } ranked_score_t;

    code_t         held_scores [MAX_SCORES];
    int            held_count;
    logic [20:0]   score_sum;
    logic          scores_dropped;
    ranked_score_t ranked_due [$];
    int            fails = 0;

    // Store or drop the score; on the final one, sort the set and queue its results.
    function automatic void predict_score_request(input code_t s, input logic last);
        code_t         ordered [MAX_SCORES];
        code_t         tmp;
        logic [20:0]   mean_wide;
        int            n;
        int            i;
        int            j;
        ranked_score_t r;
        if (held_count < MAX_SCORES)
        begin
            held_scores[held_count] = s;
            held_count++;
            score_sum += 21'(s);
        end
        else
        begin
            scores_dropped = 1'b1;
        end
        if (!last)
            return;
        n = held_count;
        for (i = 0; i < n; i++)
            ordered[i] = held_scores[i];
        for (i = 1; i < n; i++)
        begin
            tmp = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > tmp)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = tmp;
        end
        mean_wide = score_sum / 21'(n);
        for (i = 0; i < n; i++)
        begin
            r.sorted = ordered[i];
            r.mean   = mean_wide[ssa_pkg::SCORE_W-1:0];
            r.ovf    = scores_dropped;
            r.eor    = (i == n - 1);
            ranked_due.push_back(r);
        end
        held_count     = 0;
        score_sum      = '0;
        scores_dropped = 1'b0;
    endfunction

    function automatic void check_ranked_score();
        ranked_score_t want;
        if (ranked_due.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("ERROR: result with none due: sorted=%0d mean=%0d ovf=%0b eor=%0b",
                         sorted_score, mean_score, overflowed, end_of_run);
        end
        else
        begin
            want = ranked_due.pop_front();
            if (want.sorted !== sorted_score || want.mean !== mean_score ||
                want.ovf !== overflowed || want.eor !== end_of_run)
            begin
                fails++;
                if (fails <= 10)
                    $display("ERROR: sorted/mean/ovf/eor expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                             want.sorted, want.mean, want.ovf, want.eor,
                             sorted_score, mean_score, overflowed, end_of_run);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count     = 0;
            score_sum      = '0;
            scores_dropped = 1'b0;
            ranked_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_ranked_score();
            if (in_valid && in_ready)
                predict_score_request(score, final_score);
        end
        fail_count  = fails;
        results_due = ranked_due.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef logic [ssa_pkg::SCORE_W-1:0] code_t;

    localparam int MAX_SCORES   = 64;
    localparam int SCORE_TOP    = 25600;    // 100.0 in Q7.8
    localparam int CODE_TOP     = 32767;    // largest 15-bit code
    localparam int ITEM_TARGET  = 480;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off after reset
    localparam int QUIET_LIMIT  = 20000;    // cycles with no request or result moving
    localparam int DRAIN_CYCLES = 50;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    code_t score = '0;
    logic  final_score = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    code_t sorted_score;
    code_t mean_score;
    logic  overflowed;
    logic  end_of_run;

    int fail_count;
    int results_due;
    int quiet_cycles = 0;
    int requests_sent = 0;

    always #6 clk = ~clk;

    selection_sort_with_average_core #(
        .MAX_SCORES(MAX_SCORES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .score        (score),
        .final_score  (final_score),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_score (sorted_score),
        .mean_score   (mean_score),
        .overflowed   (overflowed),
        .end_of_run   (end_of_run)
    );

    score_sort_checker #(
        .MAX_SCORES(MAX_SCORES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .score        (score),
        .final_score  (final_score),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_score (sorted_score),
        .mean_score   (mean_score),
        .overflowed   (overflowed),
        .end_of_run   (end_of_run),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // Idle length between handshakes: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one score request and hold it until taken. Keep in_valid high straight
    // into the next request when no gap is drawn, so valid never drops and rises
    // within one step.
    task automatic send_score(input code_t s, input logic last);
        int idle;
        idle = pick_gap();
        @(negedge clk);
        if (idle > 0)
        begin
            in_valid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid    = 1'b1;
        score       = s;
        final_score = last;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // Draw one score: mostly in range, some repeats of the previous one, some at
    // the range ends, and some drawn from the whole 15-bit code range, top bit included.
    function automatic code_t pick_score(input code_t prev);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return code_t'($urandom_range(0, SCORE_TOP));
        else if (roll < 85)
            return prev;
        else if (roll < 90)
            return ($urandom_range(0, 1) != 0) ? code_t'(SCORE_TOP) : '0;
        else
            return code_t'($urandom_range(0, CODE_TOP));
    endfunction

    // Set size: a few forced full and overfull sets early, then mostly small sets
    // with a sprinkling of sizes around the store capacity.
    function automatic int pick_set_size(input int set_no);
        int roll;
        if (set_no == 1)
            return MAX_SCORES;          // exactly full, nothing dropped
        if (set_no == 3)
            return MAX_SCORES + 1;      // only the final score is dropped
        if (set_no == 5)
            return MAX_SCORES + 8;      // several dropped, final among them
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 8);
        else if (roll < 92)
            return $urandom_range(9, 40);
        else
            return $urandom_range(MAX_SCORES - 4, MAX_SCORES + 10);
    endfunction

    // Reset once, then run the directed sets followed by random sets.
    initial
    begin
        code_t prev;
        int    set_no;
        int    set_size;
        int    k;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // single-score set at the bottom code
        send_score(15'd0, 1'b1);
        // range ends, an out-of-range code, top bit alone, and a tie
        send_score(code_t'(SCORE_TOP), 1'b0);
        send_score(15'd0, 1'b0);
        send_score(code_t'(CODE_TOP), 1'b0);
        send_score(15'd1, 1'b0);
        send_score(15'h4000, 1'b0);
        send_score(15'd300, 1'b0);
        send_score(15'd300, 1'b0);
        send_score(15'd12800, 1'b1);
        // all scores equal
        send_score(15'd7, 1'b0);
        send_score(15'd7, 1'b0);
        send_score(15'd7, 1'b0);
        send_score(15'd7, 1'b1);
        // alternating bit patterns, descending order on arrival
        send_score(15'h5555, 1'b0);
        send_score(15'h2AAA, 1'b0);
        send_score(15'h0001, 1'b1);
        // single-score set at the top code
        send_score(code_t'(CODE_TOP), 1'b1);

        set_no = 0;
        prev   = '0;
        while (requests_sent < ITEM_TARGET)
        begin
            set_size = pick_set_size(set_no);
            for (k = 0; k < set_size; k++)
            begin
                prev = pick_score(prev);
                send_score(prev, k == set_size - 1);
            end
            set_no++;
        end

        @(negedge clk);
        in_valid    = 1'b0;
        final_score = 1'b0;

        // Drain: wait for every due result, then give the block a little more time
        // to show any stray result.
        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: hold off for a long stretch first so the block fills up and
    // stalls its input, then stall at random after each taken result.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        repeat (HOLD_CYCLES) @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
            end
            @(posedge clk);
            if (out_valid && out_ready)
                stall_left = pick_gap();
        end
    end

    // Watchdog: count cycles in which neither channel moves.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// File: selection_sort_with_average_core.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/ssa_div.sv
sv/selection_sort_with_average_core.sv
sv/ssa_checker.sv
tb/score_sort_checker.sv
tb/testbench.sv
